// ===== hdl/psvb_pkg.sv =====
// Shared constants, types and state codes of the panned sine voice bank.
package psvb_pkg;

  localparam int unsigned VOICES          = 32;
  localparam int unsigned SAMPLE_RATE     = 44100;
  localparam int unsigned SINE_TABLE_BITS = 10;

  localparam int unsigned VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

  // numerator of the period division, frequency being Q14.8
  localparam logic [31:0] PER_NUM = 32'(SAMPLE_RATE * 256);
  localparam logic [11:0] PER_MAX = 12'd4095;
  localparam logic [15:0] ANG_MASK =
    16'(16'hFFFF << (16 - SINE_TABLE_BITS));

  // divide by five as multiply by ceil(2^24/5), exact below 2^22
  localparam logic [21:0] GLIDE_RCP = 22'd3355444;

  localparam logic [1:0] CMD_RENDER = 2'd0;
  localparam logic [1:0] CMD_SET    = 2'd1;
  localparam logic [1:0] CMD_GLIDE  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [21:0]        freq;
    logic [13:0]        target;
    logic [11:0]        period;
    logic [15:0]        phase;
    logic [15:0]        pan;
    logic signed [15:0] last;
  } voice_t;

  localparam voice_t VOICE_RESET = '{
    freq:   22'd112640,
    target: 14'd440,
    period: 12'd100,
    phase:  16'd0,
    pan:    16'd32768,
    last:   16'sd0
  };

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [21:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [21:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic               valid;
    logic signed [19:0] left;
    logic signed [19:0] right;
    logic               frame;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_GSTEP,
    S_GADD,
    S_GPER,
    S_GPERW,
    S_GWR,
    S_RMOD,
    S_RANG,
    S_RANGW,
    S_SIN1,
    S_SIN2,
    S_SIN3,
    S_SIN4,
    S_TSC,
    S_SLEW1,
    S_SLEW2,
    S_MIX,
    S_ACC,
    S_FINISH
  } eng_state_e;

endpackage

// ===== hdl/psvb_if.sv =====
// Request and result channel interfaces of the voice bank.
interface psvb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] sample_time;
  logic [4:0]  voice_index;
  logic [13:0] target_hz;
  logic [15:0] phase_offset;
  logic [15:0] right_gain;

  modport source (output valid, cmd, sample_time, voice_index, target_hz,
                  phase_offset, right_gain, input ready);
  modport sink   (input valid, cmd, sample_time, voice_index, target_hz,
                  phase_offset, right_gain, output ready);
endinterface

interface psvb_out_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] left_sample;
  logic signed [19:0] right_sample;
  logic               frame_valid;

  modport source (output valid, left_sample, right_sample, frame_valid,
                  input ready);
  modport sink   (input valid, left_sample, right_sample, frame_valid,
                  output ready);
endinterface

// ===== hdl/psvb_div.sv =====
// Restoring divider, one quotient bit per cycle.
module psvb_div
  import psvb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [31:0] num_q;
  logic [21:0] rem_q, den_q;
  logic [22:0] trial;
  logic        ge;
  logic [22:0] rem_n;

  assign trial = {rem_q, num_q[31]};
  assign ge    = trial >= {1'b0, den_q};
  assign rem_n = ge ? (trial - {1'b0, den_q}) : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      num_q <= req_i.dividend;
      den_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[30:0], ge};
      rem_q <= rem_n[21:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== hdl/psvb_engine.sv =====
// Voice memory and the sequencer that renders, glides and sets voices.
module psvb_engine
  import psvb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  psvb_in_if.sink   in_i,
  output div_req_t  div_req_o,
  input  div_rsp_t  div_rsp_i,
  output res_t      res_o,
  input  logic      res_ready_i
);

  eng_state_e state_q, state_d;

  // voice memory, valid bits stand in for the reset values
  voice_t              mem [VOICES];
  logic [VOICES-1:0]   vld_q;
  voice_t              rd_q;
  logic                rd_vld_q;
  voice_t              eff;
  logic                mem_we;
  voice_t              wr_rec;
  logic [VIDX_W-1:0]   rd_addr;

  logic [1:0]          cmd_q;
  logic [31:0]         stime_q;
  logic [4:0]          vi_q;
  logic [13:0]         tgt_q;
  logic [15:0]         ph_q;
  logic [15:0]         pan_q;
  logic [VIDX_W-1:0]   vcnt_q;
  logic                last_voice;
  logic                vi_ok;

  voice_t              cur_q;
  logic [22:0]         gsum_q;
  logic [18:0]         stp_q;
  logic [21:0]         f_q;
  logic [11:0]         per_q;
  logic [11:0]         tm_q;
  logic [15:0]         ang_q;
  logic [14:0]         x_q;
  logic [1:0]          quad_q;
  logic [14:0]         x2_q;
  logic [13:0]         r1_q;
  logic [14:0]         r2_q;
  logic signed [16:0]  s_q;
  logic signed [16:0]  t_q;
  logic signed [17:0]  dl_q;
  logic signed [15:0]  tf_q;
  logic signed [33:0]  lp_q, rp_q;
  logic signed [39:0]  lacc_q, racc_q;
  logic                neg_q;

  logic                accept;
  assign accept = in_i.valid && in_i.ready;

  assign vi_ok      = {2'b00, vi_q} < 7'(VOICES);
  assign last_voice = vcnt_q == VIDX_W'(VOICES - 1);
  assign rd_addr    = (cmd_q == CMD_SET) ? vi_q[VIDX_W-1:0] : vcnt_q;
  assign eff        = rd_vld_q ? rd_q : VOICE_RESET;

  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) begin
      rd_q <= mem[rd_addr];
    end
    if (mem_we) begin
      mem[rd_addr] <= wr_rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (state_q == S_READ) rd_vld_q <= vld_q[rd_addr];
      if (mem_we) vld_q[rd_addr] <= 1'b1;
    end
  end

  // glide step arithmetic: step = (|delta| + 10) / 20 as /4 then /5
  logic signed [23:0] delta;
  logic [22:0]        gmag;
  logic [42:0]        gprod;
  logic signed [23:0] fnew;
  assign delta = $signed({2'b00, eff.target, 8'd0}) - $signed({2'b00, eff.freq});
  assign gmag  = delta[23] ? 23'(-delta) : 23'(delta);
  assign gprod = 43'(gsum_q[22:2]) * 43'(GLIDE_RCP);
  assign fnew  = neg_q ? ($signed({2'b00, cur_q.freq}) - $signed({5'd0, stp_q}))
                       : ($signed({2'b00, cur_q.freq}) + $signed({5'd0, stp_q}));

  logic [11:0] per_eff;
  assign per_eff = (eff.period == 12'd0) ? 12'd1 : eff.period;

  // sine quarter-wave fold
  logic [15:0] angm;
  logic [14:0] xf;
  assign angm = ang_q & ANG_MASK;
  assign xf   = angm[14] ? (15'h4000 - {1'b0, angm[13:0]}) : {1'b0, angm[13:0]};

  logic [29:0] xx;
  logic [25:0] x2c;
  logic [29:0] x2r;
  logic [29:0] xr;
  logic [16:0] smag;
  assign xx   = 30'(x_q) * 30'(x_q);
  assign x2c  = 26'(x2_q) * 26'd1302;
  assign x2r  = 30'(x2_q) * 30'(r1_q);
  assign xr   = 30'(x_q) * 30'(r2_q);
  assign smag = (xr[29:13] > 17'd32767) ? 17'd32767 : xr[29:13];

  logic [16:0] sm;
  logic [31:0] tprod;
  assign sm    = s_q[16] ? 17'(-s_q) : 17'(s_q);
  assign tprod = 32'(sm) * 32'd6554 + 32'd32768;

  logic [17:0] dm;
  logic [31:0] dprod;
  logic [15:0] dsc;
  assign dm    = dl_q[17] ? 18'(-dl_q) : 18'(dl_q);
  assign dprod = 32'(dm) * 32'd1311 + 32'd32768;
  assign dsc   = dprod[31:16];

  logic [16:0] gl;
  assign gl = 17'h10000 - {1'b0, cur_q.pan};

  // slew-limited sample of the current voice
  function automatic logic signed [15:0] tmix_next();
    if (dl_q > 18'sd655 || dl_q < -18'sd655) begin
      return dl_q[17] ? 16'(cur_q.last - $signed(dsc))
                      : 16'(cur_q.last + $signed(dsc));
    end
    return t_q[15:0];
  endfunction

  // final rounding and saturation of both mixes
  function automatic logic signed [19:0] mix_out(input logic signed [39:0] a);
    logic [39:0]        m;
    logic [39:0]        r;
    logic signed [40:0] v;
    m = a[39] ? 40'(-a) : 40'(a);
    r = (m + 40'd32768) >> 16;
    v = a[39] ? -$signed({1'b0, r}) : $signed({1'b0, r});
    if (v > 41'sd524287) return 20'sd524287;
    if (v < -41'sd524288) return -20'sd524288;
    return v[19:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_i.cmd)
            CMD_SET, CMD_GLIDE, CMD_RENDER: state_d = S_READ;
            default:                        state_d = S_FINISH;
          endcase
        end
      end
      S_READ: begin
        if (cmd_q == CMD_SET && !vi_ok) state_d = S_FINISH;
        else                            state_d = S_LOAD;
      end
      S_LOAD: begin
        case (cmd_q)
          CMD_SET:   state_d = S_FINISH;
          CMD_GLIDE: state_d = S_GSTEP;
          default:   state_d = S_RMOD;
        endcase
      end
      S_GSTEP: state_d = S_GADD;
      S_GADD:  state_d = S_GPER;
      S_GPER:  state_d = (f_q == 22'd0) ? S_GWR : S_GPERW;
      S_GPERW: if (div_rsp_i.done) state_d = S_GWR;
      S_GWR:   state_d = last_voice ? S_FINISH : S_READ;
      S_RMOD:  if (div_rsp_i.done) state_d = S_RANG;
      S_RANG:  state_d = S_RANGW;
      S_RANGW: if (div_rsp_i.done) state_d = S_SIN1;
      S_SIN1:  state_d = S_SIN2;
      S_SIN2:  state_d = S_SIN3;
      S_SIN3:  state_d = S_SIN4;
      S_SIN4:  state_d = S_TSC;
      S_TSC:   state_d = S_SLEW1;
      S_SLEW1: state_d = S_SLEW2;
      S_SLEW2: state_d = S_MIX;
      S_MIX:   state_d = S_ACC;
      S_ACC:   state_d = last_voice ? S_FINISH : S_READ;
      S_FINISH: if (res_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = 1'b0;
    mem_we     = 1'b0;
    wr_rec     = cur_q;
    div_req_o  = '{start: 1'b0, dividend: 32'd0, divisor: 22'd1};
    res_o      = '{valid: 1'b0, left: 20'sd0, right: 20'sd0, frame: 1'b0};
    case (state_q)
      S_IDLE: in_i.ready = 1'b1;
      S_LOAD: begin
        if (cmd_q == CMD_SET) begin
          mem_we        = 1'b1;
          wr_rec        = eff;
          wr_rec.target = tgt_q;
          wr_rec.phase  = ph_q;
          wr_rec.pan    = pan_q;
        end else if (cmd_q == CMD_RENDER) begin
          div_req_o = '{start: 1'b1, dividend: stime_q, divisor: 22'(per_eff)};
        end
      end
      S_GPER: begin
        if (f_q != 22'd0) begin
          div_req_o = '{start: 1'b1, dividend: PER_NUM, divisor: f_q};
        end
      end
      S_GWR: begin
        mem_we        = 1'b1;
        wr_rec.freq   = f_q;
        wr_rec.period = per_q;
      end
      S_RANG: begin
        div_req_o = '{start: 1'b1, dividend: {4'd0, tm_q, 16'd0},
                      divisor: 22'(per_q)};
      end
      S_ACC: begin
        mem_we      = 1'b1;
        wr_rec.last = tf_q;
      end
      S_FINISH: begin
        res_o.valid = 1'b1;
        if (cmd_q == CMD_RENDER) begin
          res_o.left  = mix_out(lacc_q);
          res_o.right = mix_out(racc_q);
          res_o.frame = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q <= '0;
    end else begin
      if (accept) vcnt_q <= '0;
      else if (state_q == S_GWR || state_q == S_ACC) vcnt_q <= vcnt_q + VIDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_q   <= in_i.cmd;
          stime_q <= in_i.sample_time;
          vi_q    <= in_i.voice_index;
          tgt_q   <= in_i.target_hz;
          ph_q    <= in_i.phase_offset;
          pan_q   <= in_i.right_gain;
          lacc_q  <= '0;
          racc_q  <= '0;
        end
      end
      S_LOAD: begin
        cur_q  <= eff;
        neg_q  <= delta[23];
        gsum_q <= gmag + 23'd10;
        per_q  <= per_eff;
      end
      S_GSTEP: stp_q <= gprod[42:24];
      S_GADD: begin
        if (fnew < 24'sd0)                 f_q <= 22'd0;
        else if (fnew > 24'sh3FFFFF)       f_q <= 22'h3FFFFF;
        else                               f_q <= fnew[21:0];
      end
      S_GPER: if (f_q == 22'd0) per_q <= PER_MAX;
      S_GPERW: begin
        if (div_rsp_i.done) begin
          if (div_rsp_i.quot > 32'(PER_MAX))  per_q <= PER_MAX;
          else if (div_rsp_i.quot == 32'd0)   per_q <= 12'd1;
          else                                per_q <= div_rsp_i.quot[11:0];
        end
      end
      S_RMOD:  if (div_rsp_i.done) tm_q <= div_rsp_i.rem[11:0];
      S_RANGW: if (div_rsp_i.done) ang_q <= div_rsp_i.quot[15:0] + cur_q.phase;
      S_SIN1: begin
        x_q    <= xf;
        quad_q <= angm[15:14];
      end
      S_SIN2: begin
        x2_q <= xx[28:14];
      end
      S_SIN3: begin
        r1_q <= 14'(14'd10583 - 14'(x2c[25:14]));
      end
      S_SIN4: begin
        r2_q <= 15'(15'd25736 - 15'(x2r[29:14]));
      end
      S_TSC: begin
        s_q <= quad_q[1] ? -$signed(smag) : $signed(smag);
      end
      S_SLEW1: begin
        t_q <= s_q[16] ? -$signed({4'd0, tprod[28:16]}) : $signed({4'd0, tprod[28:16]});
      end
      S_SLEW2: begin
        dl_q <= 18'(t_q) - 18'(cur_q.last);
      end
      S_MIX: begin
        tf_q <= tmix_next();
      end
      S_ACC: begin
        lacc_q <= lacc_q + 40'(lp_q);
        racc_q <= racc_q + 40'(rp_q);
      end
      default: ;
    endcase
  end

  // pan products are formed alongside the slew result
  always_ff @(posedge clk_i) begin
    if (state_q == S_MIX) begin
      lp_q <= 34'(tmix_next() * $signed({1'b0, gl}));
      rp_q <= 34'(tmix_next() * $signed({2'b00, cur_q.pan}));
    end
  end

endmodule

// ===== hdl/panned_sine_voice_bank_top.sv =====
// Top level of the panned sine voice bank: engine, divider, result register.
//
//  channel  dir  payload                                       request taken
//  in_i     in   cmd sample_time voice_index target_hz ...     valid & ready
//  out_o    out  left_sample right_sample frame_valid           valid & ready
//
// One request is worked at a time. A glide tick and a render step through
// the voices one by one; both wait on the shared divider, which a glide uses
// for the period (skipped once a frequency is zero) and a render for the
// modulo and the angle. Reset clears the per-voice valid bits at once, so
// unwritten voices read their reset values.
// The result register lets the next request in while a result still waits;
// a stalled result holds the engine only once a second result is ready.
module panned_sine_voice_bank_top
  import psvb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  psvb_in_if.sink   in_i,
  psvb_out_if.source out_o
);

  div_req_t div_req;
  div_rsp_t div_rsp;
  res_t     res;
  logic     res_ready;

  logic               out_vld_q;
  logic signed [19:0] left_q, right_q;
  logic               frame_q;

  psvb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  psvb_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // result register is free when empty or being drained this cycle
  assign res_ready = !out_vld_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) begin
      left_q  <= res.left;
      right_q <= res.right;
      frame_q <= res.frame;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.left_sample  = left_q;
  assign out_o.right_sample = right_q;
  assign out_o.frame_valid  = frame_q;

endmodule
